FILE: sv/rdsm_pkg.sv
// Package for the regex dot-star matcher: widths, register indexes, config type.
`default_nettype none
package rdsm_pkg;

  localparam int unsigned MAX_ELEMENTS_C = 16;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned MASK_W         = 16;
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned Q_DEPTH_C      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LOW  = 3'd0,
    REG_CHARS_HIGH = 3'd1,
    REG_WILDCARD   = 3'd2,
    REG_STAR       = 3'd3,
    REG_COUNT      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] chars_high;
    logic [CFG_DATA_W-1:0] chars_low;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [MASK_W-1:0]     star_mask;
    logic [COUNT_W-1:0]    element_count;
  } cfg_t;

endpackage
`default_nettype wire

FILE: sv/rdsm_in_if.sv
// Input channel interface: one text character per transfer.
`default_nettype none
interface rdsm_in_if import rdsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              char_present;
  logic              last_char;

  modport source (output valid, text_char, char_present, last_char, input ready);
  modport sink   (input valid, text_char, char_present, last_char, output ready);
endinterface
`default_nettype wire

FILE: sv/rdsm_out_if.sv
// Result channel interface: one verdict per transfer.
`default_nettype none
interface rdsm_out_if;
  logic valid;
  logic ready;
  logic match;
  logic end_of_string;

  modport source (output valid, match, end_of_string, input ready);
  modport sink   (input valid, match, end_of_string, output ready);
endinterface
`default_nettype wire

FILE: sv/rdsm_front.sv
// Front end: accepts characters and classifies them against every pattern element.
`default_nettype none
module rdsm_front import rdsm_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_C
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  rdsm_in_if.sink                      in_ch,
  output logic                         push_valid,
  input  wire logic                    push_ready,
  output logic [MAX_ELEMENTS+1:0]      push_data
);

  logic                    st_valid_r, st_valid_nxt;
  logic [MAX_ELEMENTS-1:0] st_hit_r, st_hit_nxt;
  logic                    st_present_r, st_present_nxt;
  logic                    st_last_r, st_last_nxt;
  logic [2*CFG_DATA_W-1:0] chars;
  logic                    accept;

  assign chars       = {cfg.chars_high, cfg.chars_low};
  assign in_ch.ready = !st_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = st_valid_r;
  assign push_data   = {st_hit_r, st_present_r, st_last_r};

  always_comb begin
    st_valid_nxt   = st_valid_r;
    st_hit_nxt     = st_hit_r;
    st_present_nxt = st_present_r;
    st_last_nxt    = st_last_r;
    if (accept) begin
      st_valid_nxt   = 1'b1;
      st_present_nxt = in_ch.char_present;
      st_last_nxt    = in_ch.last_char;
      // per-element hit: wildcard or exact code compare
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        st_hit_nxt[i] = cfg.wildcard_mask[i] || (chars[i*CHAR_W +: CHAR_W] == in_ch.text_char);
      end
    end else if (push_ready) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
    st_hit_r     <= st_hit_nxt;
    st_present_r <= st_present_nxt;
    st_last_r    <= st_last_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/rdsm_queue.sv
// Short FIFO between the classifier front end and the position-set back end.
`default_nettype none
module rdsm_queue import rdsm_pkg::*; #(
  parameter int unsigned WIDTH = MAX_ELEMENTS_C + 2,
  parameter int unsigned DEPTH = Q_DEPTH_C
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rdsm_back.sv
// Back end: advances the active position set and registers one verdict per item.
`default_nettype none
module rdsm_back import rdsm_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_C
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    q_valid,
  output logic                         q_pop,
  input  wire logic [MAX_ELEMENTS+1:0] q_data,
  rdsm_out_if.source                   out_ch
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [MAX_ELEMENTS:0]   active_r, active_nxt;
  logic [MAX_ELEMENTS:0]   live, pre, nxt_raw, post, fin;
  logic [MAX_ELEMENTS-1:0] en, star, hit;
  logic [CW-1:0]           n;
  logic                    present, last;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_match_r, out_match_nxt;
  logic                    out_eos_r, out_eos_nxt;

  assign hit     = q_data[MAX_ELEMENTS+1:2];
  assign present = q_data[1];
  assign last    = q_data[0];
  assign star    = cfg.star_mask[MAX_ELEMENTS-1:0];
  assign q_pop   = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    // clamp element count
    if (32'(cfg.element_count) > MAX_ELEMENTS) begin
      n = CW'(MAX_ELEMENTS);
    end else begin
      n = CW'(cfg.element_count);
    end
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      live[k] = (k <= int'(n));
    end
    en = live[MAX_ELEMENTS:1];

    // closure over starred elements, then one character step, then closure again
    pre = active_r & live;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (en[i] && star[i] && pre[i]) pre[i+1] = 1'b1;
    end
    nxt_raw = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (en[i] && pre[i] && hit[i]) begin
        if (star[i]) nxt_raw[i] = 1'b1;
        else nxt_raw[i+1] = 1'b1;
      end
    end
    post = nxt_raw & live;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (en[i] && star[i] && post[i]) post[i+1] = 1'b1;
    end
    fin = present ? post : pre;

    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_eos_nxt   = out_eos_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      out_match_nxt = fin[n];
      out_eos_nxt   = last;
      if (last) begin
        active_nxt = (MAX_ELEMENTS+1)'(1);
      end else if (present) begin
        active_nxt = nxt_raw;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.match         = out_match_r;
  assign out_ch.end_of_string = out_eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= (MAX_ELEMENTS+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_match_r <= out_match_nxt;
    out_eos_r   <= out_eos_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/regex_dot_star_matcher.sv
// Top level of the regex dot-star matcher: config registers, front end, queue, back end.
// Whole-string matcher for a pattern of up to MAX_ELEMENTS elements, each a literal
// byte or a dot wildcard, optionally starred. Load the five pattern registers while
// idle, then stream text one character per transfer; every input item yields exactly
// one result telling whether the text since the start of the string matches the whole
// pattern. An item with char_present low consumes nothing (use it for an empty string)
// and last_char closes the string and restarts the position set. The block sustains one
// item per clock while neither side stalls: the front end compares the character with
// every element, and the back end updates the 17-bit position set and its star closure.
// A result passes through the classify register loaded at the input transfer, a queue
// entry and the output register before it is offered, and either side may stall
// independently.
`default_nettype none
module regex_dot_star_matcher import rdsm_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_C
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rdsm_in_if.sink                    in_ch,
  rdsm_out_if.source                 out_ch
);

  localparam int unsigned QW = MAX_ELEMENTS + 2;

  cfg_t          cfg_r, cfg_nxt;
  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CHARS_LOW:  cfg_nxt.chars_low     = cfg_data;
        REG_CHARS_HIGH: cfg_nxt.chars_high    = cfg_data;
        REG_WILDCARD:   cfg_nxt.wildcard_mask = cfg_data[MASK_W-1:0];
        REG_STAR:       cfg_nxt.star_mask     = cfg_data[MASK_W-1:0];
        REG_COUNT:      cfg_nxt.element_count = cfg_data[COUNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rdsm_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rdsm_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH_C)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  rdsm_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: bench/regex_dot_star_matcher_tb.sv
// Self-checking testbench for regex_dot_star_matcher: directed and random text against a position-set predictor.
`timescale 1ns / 1ps
module regex_dot_star_matcher_tb;
  import rdsm_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              char_present;
    logic              last_char;
  } text_item_t;

  typedef struct packed {
    logic match;
    logic end_of_string;
  } verdict_t;

  typedef enum int {TXT_MATCH, TXT_MUTATED, TXT_NOISE} text_style_t;

  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned POS_W        = MAX_ELEMENTS_C + 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rdsm_in_if  in_ch ();
  rdsm_out_if out_ch ();

  regex_dot_star_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of the pattern registers and the position set
  logic [CFG_DATA_W-1:0] pat_chars_lo;
  logic [CFG_DATA_W-1:0] pat_chars_hi;
  logic [MASK_W-1:0]     wild_bits;
  logic [MASK_W-1:0]     star_bits;
  logic [COUNT_W-1:0]    elem_count;
  logic [POS_W-1:0]      live_positions = POS_W'(1);

  text_item_t  pending_text[$];
  verdict_t    expected_verdicts[$];
  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned verdict_errors = 0;
  logic        calm           = 1'b0;
  logic        rx_hold        = 1'b0;
  logic        wide_alphabet  = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic int unsigned used_elements();
    return (elem_count > MAX_ELEMENTS_C) ? MAX_ELEMENTS_C : int'(elem_count);
  endfunction

  function automatic logic [CHAR_W-1:0] element_code(int unsigned i);
    return (i < 8) ? pat_chars_lo[8*i +: 8] : pat_chars_hi[8*(i-8) +: 8];
  endfunction

  // drop positions past the pattern end, then let starred elements be skipped
  function automatic logic [POS_W-1:0] star_closure(logic [POS_W-1:0] s, int unsigned n);
    logic [POS_W-1:0] r;
    int unsigned      k;
    r = s;
    for (k = 0; k < POS_W; k++)
      if (k > n) r[k] = 1'b0;
    for (k = 0; k < n; k++)
      if (r[k] && star_bits[k]) r[k+1] = 1'b1;
    return r;
  endfunction

  function automatic logic advance_positions(text_item_t it);
    int unsigned      n;
    int unsigned      i;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] nxt;
    logic             verdict;
    n = used_elements();
    s = star_closure(live_positions, n);
    if (it.char_present) begin
      nxt = '0;
      for (i = 0; i < n; i++) begin
        if (s[i] && (wild_bits[i] || element_code(i) == it.text_char)) begin
          if (star_bits[i]) nxt[i] = 1'b1;
          else nxt[i+1] = 1'b1;
        end
      end
      s = star_closure(nxt, n);
      live_positions = nxt;
    end
    verdict = s[n];
    if (it.last_char) live_positions = POS_W'(1);
    return verdict;
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    return wide_alphabet ? CHAR_W'($urandom_range(255)) : CHAR_W'("a" + $urandom_range(2));
  endfunction

  task automatic note_mismatch(string what, logic want, logic got);
    verdict_errors++;
    if (verdict_errors <= 10)
      $display("mismatch on %s: expected %b, got %b (item %0d)", what, want, got, accepted_items);
  endtask

  // input side: offer the oldest pending item, predict on each transfer
  always @(posedge clk) begin : text_driver
    text_item_t cur;
    verdict_t   v;
    logic       offer;
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.text_char    <= '0;
      in_ch.char_present <= 1'b0;
      in_ch.last_char    <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur = pending_text.pop_front();
        v.match = advance_positions(cur);
        v.end_of_string = cur.last_char;
        expected_verdicts.push_back(v);
        accepted_items++;
      end
      if (in_ch.valid && !in_ch.ready)
        offer = 1'b1;
      else
        offer = (pending_text.size() != 0) && (calm || $urandom_range(99) >= IDLE_PCT);
      in_ch.valid <= offer;
      if (offer) begin
        in_ch.text_char    <= pending_text[0].text_char;
        in_ch.char_present <= pending_text[0].char_present;
        in_ch.last_char    <= pending_text[0].last_char;
      end
    end
  end

  // result side: random back-pressure, compare each transfer with the oldest prediction
  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          verdict_errors++;
          if (verdict_errors <= 10)
            $display("unexpected result: match %b end_of_string %b",
                     out_ch.match, out_ch.end_of_string);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.match !== want.match)
            note_mismatch("match", want.match, out_ch.match);
          if (out_ch.end_of_string !== want.end_of_string)
            note_mismatch("end_of_string", want.end_of_string, out_ch.end_of_string);
        end
      end
      out_ch.ready <= !rx_hold && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver stall while the sender still has plenty queued, so the input backs up
  initial begin : rx_holdoff
    @(posedge clk);
    while (!(rst_n && accepted_items >= 500 && pending_text.size() > 16)) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send(logic [CHAR_W-1:0] c, logic present, logic last);
    text_item_t it;
    it.text_char    = c;
    it.char_present = present;
    it.last_char    = last;
    pending_text.push_back(it);
    queued_items++;
  endtask

  task automatic send_marker(logic last);
    send(CHAR_W'($urandom_range(255)), 1'b0, last);
  endtask

  // drive a register write after the next edge; the predictor copy follows right away since nothing is in flight
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_CHARS_LOW:  pat_chars_lo = d;
      REG_CHARS_HIGH: pat_chars_hi = d;
      REG_WILDCARD:   wild_bits    = d[MASK_W-1:0];
      REG_STAR:       star_bits    = d[MASK_W-1:0];
      REG_COUNT:      elem_count   = d[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_text.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic load_random_pattern();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] junk;
    logic [MASK_W-1:0]     wc;
    logic [MASK_W-1:0]     st;
    logic [COUNT_W-1:0]    cnt;
    int unsigned           i;
    int unsigned           r;
    wide_alphabet = ($urandom_range(7) == 0);
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = random_char();
      hi[8*i +: 8] = random_char();
    end
    for (i = 0; i < MASK_W; i++) begin
      wc[i] = ($urandom_range(4) == 0);
      st[i] = ($urandom_range(2) == 0);
    end
    r = $urandom_range(19);
    if (r == 0)     cnt = '0;
    else if (r < 3) cnt = COUNT_W'(MAX_ELEMENTS_C);
    else if (r < 5) cnt = COUNT_W'($urandom_range(31, MAX_ELEMENTS_C + 1));
    else            cnt = COUNT_W'($urandom_range(MAX_ELEMENTS_C - 1, 1));
    // unused upper data bits must be ignored
    junk = {$urandom, $urandom};
    if ($urandom_range(1) == 0) junk = '0;
    put_reg(REG_CHARS_LOW, lo);
    put_reg(REG_CHARS_HIGH, hi);
    put_reg(REG_WILDCARD, {junk[CFG_DATA_W-1:MASK_W], wc});
    put_reg(REG_STAR, {junk[CFG_DATA_W-1:MASK_W], st});
    put_reg(REG_COUNT, {junk[CFG_DATA_W-1:COUNT_W], cnt});
  endtask

  task automatic build_text(text_style_t style, output logic [CHAR_W-1:0] txt[$]);
    int unsigned n;
    int unsigned i;
    int unsigned reps;
    int unsigned pos;
    txt = {};
    if (style == TXT_NOISE) begin
      repeat ($urandom_range(6)) txt.push_back(random_char());
      return;
    end
    n = used_elements();
    for (i = 0; i < n; i++) begin
      reps = star_bits[i] ? $urandom_range(3) : 1;
      repeat (reps)
        txt.push_back(wild_bits[i] ? CHAR_W'($urandom_range(255)) : element_code(i));
    end
    if (style == TXT_MUTATED) begin
      pos = (txt.size() == 0) ? 0 : $urandom_range(txt.size() - 1);
      case ($urandom_range(3))
        0: begin
          if (txt.size() != 0) txt[pos] = random_char();
        end
        1: begin
          if (txt.size() != 0) txt.delete(pos);
        end
        2: begin
          txt.insert(pos, random_char());
        end
        default: begin
          txt.push_back(random_char());
        end
      endcase
    end
  endtask

  // close = 0 leaves the string open across the next pattern rewrite
  task automatic emit_text(logic [CHAR_W-1:0] txt[$], bit close);
    int unsigned k;
    bit          tail_marker;
    if (txt.size() == 0) begin
      if (close) send_marker(1'b1);
      return;
    end
    tail_marker = ($urandom_range(9) == 0);
    for (k = 0; k < txt.size(); k++) begin
      if ($urandom_range(19) == 0) send_marker(1'b0);
      send(txt[k], 1'b1, close && !tail_marker && (k == txt.size() - 1));
    end
    if (close && tail_marker) send_marker(1'b1);
  endtask

  initial begin : stimulus
    logic [CHAR_W-1:0] txt[$];
    int unsigned       phase;
    int unsigned       base;
    int unsigned       start;
    int unsigned       target;
    int unsigned       r;
    text_style_t       style;

    pat_chars_lo       = '0;
    pat_chars_hi       = '0;
    wild_bits          = '0;
    star_bits          = '0;
    elem_count         = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern after reset: only the empty string matches
    send_marker(1'b1);
    send(8'h00, 1'b1, 1'b1);
    send(8'hFF, 1'b1, 1'b0);
    send_marker(1'b1);
    wait_idle();

    // "a*": empty string matches, a foreign char kills the string
    put_reg(REG_CHARS_LOW, CFG_DATA_W'("a"));
    put_reg(REG_STAR, CFG_DATA_W'(1));
    put_reg(REG_COUNT, CFG_DATA_W'(1));
    finish_writes();
    send_marker(1'b1);
    send("a", 1'b1, 1'b0);
    send("a", 1'b1, 1'b1);
    send("a", 1'b1, 1'b0);
    send("b", 1'b1, 1'b0);
    send("a", 1'b1, 1'b1);
    wait_idle();

    // ".*" then literal '.', 0xFF, 0x00* and literal '*': codes of '.' and '*' stay literal
    put_reg(REG_CHARS_LOW, {24'h0, 8'h2A, 8'h00, 8'hFF, 8'h2E, 8'h78});
    put_reg(REG_WILDCARD, CFG_DATA_W'(16'h0001));
    put_reg(REG_STAR, CFG_DATA_W'(16'h0009));
    put_reg(REG_COUNT, CFG_DATA_W'(5));
    finish_writes();
    send("z", 1'b1, 1'b0);
    send(8'h2E, 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'h2A, 1'b1, 1'b1);
    send("q", 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // count above the maximum acts as sixteen; string left open at the last element
    put_reg(REG_CHARS_LOW, {8{8'h3F}});
    put_reg(REG_CHARS_HIGH, {8'hA5, {7{8'h3F}}});
    put_reg(REG_WILDCARD, '0);
    put_reg(REG_STAR, CFG_DATA_W'(16'h7FFF));
    put_reg(REG_COUNT, CFG_DATA_W'(31));
    finish_writes();
    send(8'hA5, 1'b1, 1'b0);
    wait_idle();

    // shrink the pattern mid-string: the position past the new end is dropped
    put_reg(REG_COUNT, CFG_DATA_W'(1));
    finish_writes();
    send_marker(1'b1);
    send(8'h3F, 1'b1, 1'b1);

    base  = queued_items;
    phase = 0;
    while (queued_items - base < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) begin
        wide_alphabet = 1'b1;
        put_reg(REG_CHARS_LOW, '1);
        put_reg(REG_CHARS_HIGH, '1);
        put_reg(REG_WILDCARD, '1);
        put_reg(REG_STAR, '1);
        put_reg(REG_COUNT, '1);
      end else begin
        load_random_pattern();
      end
      if (phase % 4 == 2)
        put_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_COUNT) + 1)),
                {$urandom, $urandom});
      finish_writes();
      calm   <= (phase == 3);
      target = (phase == 3) ? 200 : $urandom_range(120, 40);
      start  = queued_items;
      while (queued_items - start < target) begin
        r = $urandom_range(99);
        style = (r < 60) ? TXT_MATCH : (r < 85) ? TXT_MUTATED : TXT_NOISE;
        build_text(style, txt);
        emit_text(txt, 1'b1);
      end
      if ($urandom_range(9) < 3) begin
        build_text(TXT_MATCH, txt);
        emit_text(txt, 1'b0);
      end
      phase++;
    end

    wait_idle();
    calm <= 1'b0;
    repeat (10) @(posedge clk);
    if (verdict_errors == 0 && expected_verdicts.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
sv/rdsm_pkg.sv
sv/rdsm_in_if.sv
sv/rdsm_out_if.sv
sv/rdsm_front.sv
sv/rdsm_queue.sv
sv/rdsm_back.sv
sv/regex_dot_star_matcher.sv
bench/regex_dot_star_matcher_tb.sv
